@@ rtl/cip_pkg.sv @@
`default_nettype none

package cip_pkg;

   // Source store geometry.
   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
   localparam int INT_BITS   = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;

   // Configuration and derived size widths.
   localparam int DIM_BITS  = 10;
   localparam int RSZ_BITS  = 19;
   localparam int OFS_BITS  = 18;
   localparam int FRAC_BITS = 16;
   localparam int NUM_BITS  = RSZ_BITS + INT_BITS;
   localparam int QUO_BITS  = INT_BITS + FRAC_BITS;
   localparam int DER_CNT_BITS = $clog2(RSZ_BITS);

   // Position divider: stages times steps per stage covers every quotient bit.
   localparam int DIV_STAGES = 5;
   localparam int DIV_STEPS  = (QUO_BITS + DIV_STAGES - 1) / DIV_STAGES;
   localparam int FRONT_STAGES = 2 + DIV_STAGES;

   // Result queue.
   localparam int FIFO_DEPTH    = 8;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

   // Register file.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_TARGET_SIZE   = 2'd2;
   localparam logic [DIM_BITS-1:0] RESET_SOURCE_WIDTH  = 10'd512;
   localparam logic [DIM_BITS-1:0] RESET_SOURCE_HEIGHT = 10'd512;
   localparam logic [DIM_BITS-1:0] RESET_TARGET_SIZE   = 10'd224;

   // Request and result codes.
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef struct packed {
      logic           action;
      logic [8:0]     row;
      logic [8:0]     col;
      logic [1:0]     channel;
      logic [7:0]     red;
      logic [7:0]     green;
      logic [7:0]     blue;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] value;
      logic               status;
   } rsp_item_type;

   // Request as it travels down the address pipeline.
   typedef struct packed {
      logic        action;
      logic        bad;
      logic [1:0]  channel;
      logic [8:0]  row;
      logic [8:0]  col;
      logic [23:0] pixel;
   } tag_type;

   typedef enum logic [1:0] {
      DER_IDLE,
      DER_LOAD,
      DER_DIV,
      DER_DONE
   } der_state_type;

   // One restoring division step: returns the quotient bit over the new remainder.
   function automatic logic [RSZ_BITS:0] div_step(input logic [RSZ_BITS-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [RSZ_BITS-1:0] divisor);
      logic [RSZ_BITS:0] trial;
      logic [RSZ_BITS:0] diff;
      trial = {rem, bit_in};
      diff  = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
         div_step = {1'b1, diff[RSZ_BITS-1:0]};
      end else begin
         div_step = {1'b0, trial[RSZ_BITS-1:0]};
      end
   endfunction

   // Per-channel gain, 2^20 / (255 * std), rounded.
   function automatic logic [13:0] norm_scale(input logic [1:0] ch);
      case (ch)
         CH_RED:   norm_scale = 14'd15308;
         CH_GREEN: norm_scale = 14'd15737;
         CH_BLUE:  norm_scale = 14'd14911;
         default:  norm_scale = 14'd0;
      endcase
   endfunction

   // Per-channel offset, 2^20 * mean / std, rounded.
   function automatic logic [20:0] norm_bias(input logic [1:0] ch);
      case (ch)
         CH_RED:   norm_bias = 21'd1879323;
         CH_GREEN: norm_bias = 21'd1837207;
         CH_BLUE:  norm_bias = 21'd1552123;
         default:  norm_bias = 21'd0;
      endcase
   endfunction

endpackage

`default_nettype wire

@@ rtl/cip_div_lane.sv @@
`default_nettype none

// Pipelined restoring divider for one source axis. The dividend is
// o * (dim - 1); the quotient carries the integer position and a 16-bit fraction.
module cip_div_lane import cip_pkg::*; (
   input  logic                clock,
   input  logic                enable,
   input  logic [NUM_BITS-1:0] dividend,
   input  logic [RSZ_BITS-1:0] divisor,
   output logic [QUO_BITS-1:0] quotient
);

   logic [RSZ_BITS-1:0] rem_ff  [DIV_STAGES];
   logic [QUO_BITS-1:0] bits_ff [DIV_STAGES];
   logic [QUO_BITS-1:0] quo_ff  [DIV_STAGES];
   logic [RSZ_BITS-1:0] rem_in  [DIV_STAGES];
   logic [QUO_BITS-1:0] bits_in [DIV_STAGES];
   logic [QUO_BITS-1:0] quo_in  [DIV_STAGES];

   // Each stage retires DIV_STEPS quotient bits from its predecessor's remainder.
   always_comb begin
      logic [RSZ_BITS-1:0] r;
      logic [QUO_BITS-1:0] b;
      logic [QUO_BITS-1:0] q;
      logic [RSZ_BITS:0]   step;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            r = dividend[NUM_BITS-1 -: RSZ_BITS];
            b = {dividend[NUM_BITS-RSZ_BITS-1:0], {FRAC_BITS{1'b0}}};
            q = '0;
         end else begin
            r = rem_ff[s-1];
            b = bits_ff[s-1];
            q = quo_ff[s-1];
         end
         for (int j = 0; j < DIV_STEPS; j++) begin
            step = div_step(r, b[QUO_BITS-1], divisor);
            r    = step[RSZ_BITS-1:0];
            q    = {q[QUO_BITS-2:0], step[RSZ_BITS]};
            b    = {b[QUO_BITS-2:0], 1'b0};
         end
         rem_in[s]  = r;
         bits_in[s] = b;
         quo_in[s]  = q;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            rem_ff[s]  <= rem_in[s];
            bits_ff[s] <= bits_in[s];
            quo_ff[s]  <= quo_in[s];
         end
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/clip_image_preprocessor.sv @@
`default_nettype none

// Image preprocessor: bilinear resize, centered square crop, per-channel
// normalization to signed Q3.12.
// Requests arrive on req_valid/req_ready. A write request stores one RGB pixel
// at (row, col) and returns nothing. A query request returns one result on
// rsp_valid/rsp_ready for (channel, row, col) of the crop; a query outside the
// crop or with an unknown channel returns value 0 with status 1. Results come back in request order.
// The single-port pixel memory serves one request at a time: a query holds it for one
// read per neighbor, a write for its one write, and the next request waits until it is free.
// From accept to result an in-crop query passes 7 address stages (offset, multiply,
// five divider stages), 4 memory reads, then 6 capture, blend and scale stages.
// A flagged query skips the reads. Up to 8 queries may be past the address pipeline
// or queued; a stalled receiver fills the 8-entry result queue, req_ready drops once
// the address pipeline backs up, and nothing is lost.
// Registers are written through the APB port at byte addresses 0, 4 and 8.
// After reset and after every register write the resized size is recomputed
// by load, divide and done steps, during which req_ready is low. The pixel memory is not cleared;
// pixels must be written before a query reads them.
module clip_image_preprocessor import cip_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_item_type             req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_item_type             rsp_item,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   // ---------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------
   logic [DIM_BITS-1:0] src_w_ff, src_h_ff, tgt_ff;
   logic                cfg_wr;
   logic [1:0]          cfg_idx;

   assign pready  = 1'b1;
   assign cfg_wr  = psel & penable & pwrite & pready;
   assign cfg_idx = paddr[CSR_ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= RESET_SOURCE_WIDTH;
         src_h_ff <= RESET_SOURCE_HEIGHT;
         tgt_ff   <= RESET_TARGET_SIZE;
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_SOURCE_WIDTH:  src_w_ff <= pwdata[DIM_BITS-1:0];
            REG_SOURCE_HEIGHT: src_h_ff <= pwdata[DIM_BITS-1:0];
            REG_TARGET_SIZE:   tgt_ff   <= pwdata[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_SOURCE_WIDTH:  prdata = CSR_DATA_BITS'(src_w_ff);
         REG_SOURCE_HEIGHT: prdata = CSR_DATA_BITS'(src_h_ff);
         REG_TARGET_SIZE:   prdata = CSR_DATA_BITS'(tgt_ff);
         default:           prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Resized size: long side = target * long / short, bit-serial divide
   // ---------------------------------------------------------------
   der_state_type           der_state_ff, der_state_in;
   logic [DER_CNT_BITS-1:0] der_cnt_ff, der_cnt_in;
   logic [DIM_BITS-1:0]     der_rem_ff, der_rem_in;
   logic [RSZ_BITS-1:0]     der_quo_ff, der_quo_in;
   logic [DIM_BITS-1:0]     eff_w_ff, eff_w_in, eff_h_ff, eff_h_in;
   logic [DIM_BITS-1:0]     short_ff, short_in;
   logic [RSZ_BITS-1:0]     rw_ff, rw_in, rh_ff, rh_in;
   logic [OFS_BITS-1:0]     offx_ff, offx_in, offy_ff, offy_in;
   logic [INT_BITS-1:0]     dm1x_ff, dm1x_in, dm1y_ff, dm1y_in;
   logic [INT_BITS-1:0]     limx_ff, limx_in, limy_ff, limy_in;
   logic                    der_busy;

   logic [DIM_BITS-1:0]     clamp_w, clamp_h, major_dim;
   logic [DIM_BITS:0]       der_trial;
   logic [RSZ_BITS-1:0]     tgt_wide, rw_diff, rh_diff;

   assign der_busy = (der_state_ff != DER_IDLE);
   assign tgt_wide = RSZ_BITS'(tgt_ff);

   always_comb begin
      // Effective source size is clamped to at least 2 and to what the store holds.
      clamp_w = (src_w_ff < 10'd2) ? 10'd2 :
                (src_w_ff > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : src_w_ff;
      clamp_h = (src_h_ff < 10'd2) ? 10'd2 :
                (src_h_ff > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : src_h_ff;
      major_dim = (clamp_w > clamp_h) ? clamp_w : clamp_h;
      der_trial = {der_rem_ff, der_quo_ff[RSZ_BITS-1]};

      der_state_in = der_state_ff;
      der_cnt_in   = der_cnt_ff;
      der_rem_in   = der_rem_ff;
      der_quo_in   = der_quo_ff;
      eff_w_in     = eff_w_ff;
      eff_h_in     = eff_h_ff;
      short_in     = short_ff;
      rw_in        = rw_ff;
      rh_in        = rh_ff;
      offx_in      = offx_ff;
      offy_in      = offy_ff;
      dm1x_in      = dm1x_ff;
      dm1y_in      = dm1y_ff;
      limx_in      = limx_ff;
      limy_in      = limy_ff;

      case (der_state_ff)
         DER_IDLE: ;
         DER_LOAD: begin
            eff_w_in     = clamp_w;
            eff_h_in     = clamp_h;
            short_in     = (clamp_w < clamp_h) ? clamp_w : clamp_h;
            der_quo_in   = RSZ_BITS'(tgt_ff) * RSZ_BITS'(major_dim);
            der_rem_in   = '0;
            der_cnt_in   = '0;
            der_state_in = DER_DIV;
         end
         DER_DIV: begin
            if (der_trial >= {1'b0, short_ff}) begin
               der_rem_in = DIM_BITS'(der_trial - {1'b0, short_ff});
               der_quo_in = {der_quo_ff[RSZ_BITS-2:0], 1'b1};
            end else begin
               der_rem_in = der_trial[DIM_BITS-1:0];
               der_quo_in = {der_quo_ff[RSZ_BITS-2:0], 1'b0};
            end
            der_cnt_in = der_cnt_ff + 1'b1;
            if (der_cnt_ff == DER_CNT_BITS'(RSZ_BITS - 1)) begin
               der_state_in = DER_DONE;
            end
         end
         DER_DONE: begin
            rw_in   = (eff_w_ff < eff_h_ff) ? tgt_wide : der_quo_ff;
            rh_in   = (eff_w_ff > eff_h_ff) ? tgt_wide : der_quo_ff;
            dm1x_in = INT_BITS'(eff_w_ff - 1'b1);
            dm1y_in = INT_BITS'(eff_h_ff - 1'b1);
            limx_in = INT_BITS'(eff_w_ff - 2'd2);
            limy_in = INT_BITS'(eff_h_ff - 2'd2);
            der_state_in = DER_IDLE;
         end
         default: der_state_in = DER_LOAD;
      endcase

      // Crop offsets are loaded together with the resized size.
      rw_diff = rw_in - tgt_wide;
      rh_diff = rh_in - tgt_wide;
      if (der_state_ff == DER_DONE) begin
         offx_in = rw_diff[RSZ_BITS-1:1];
         offy_in = rh_diff[RSZ_BITS-1:1];
      end

      if (cfg_wr) begin
         der_state_in = DER_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         der_state_ff <= DER_LOAD;
      end else begin
         der_state_ff <= der_state_in;
      end
   end

   always_ff @(posedge clock) begin
      der_cnt_ff <= der_cnt_in;
      der_rem_ff <= der_rem_in;
      der_quo_ff <= der_quo_in;
      eff_w_ff   <= eff_w_in;
      eff_h_ff   <= eff_h_in;
      short_ff   <= short_in;
      rw_ff      <= rw_in;
      rh_ff      <= rh_in;
      offx_ff    <= offx_in;
      offy_ff    <= offy_in;
      dm1x_ff    <= dm1x_in;
      dm1y_ff    <= dm1y_in;
      limx_ff    <= limx_in;
      limy_ff    <= limy_in;
   end

   // ---------------------------------------------------------------
   // Address pipeline: crop offset, scale, divide by resized size
   // ---------------------------------------------------------------
   logic                req_acc, adv, take;
   logic                v_ff   [FRONT_STAGES];
   tag_type             tag_ff [FRONT_STAGES];
   tag_type             tag_new;
   logic [RSZ_BITS-1:0] ox_ff, oy_ff;
   logic [NUM_BITS-1:0] nx_ff, ny_ff;
   logic [QUO_BITS-1:0] qx, qy;

   assign adv       = !v_ff[FRONT_STAGES-1] || take;
   assign req_ready = adv && !der_busy;
   assign req_acc   = req_valid && req_ready;

   always_comb begin
      tag_new.action  = req_item.action;
      tag_new.bad     = ({1'b0, req_item.row} >= tgt_ff) || ({1'b0, req_item.col} >= tgt_ff)
                        || (req_item.channel != CH_RED && req_item.channel != CH_GREEN
                            && req_item.channel != CH_BLUE);
      tag_new.channel = req_item.channel;
      tag_new.row     = req_item.row;
      tag_new.col     = req_item.col;
      tag_new.pixel   = {req_item.red, req_item.green, req_item.blue};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FRONT_STAGES; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= req_acc;
         for (int k = 1; k < FRONT_STAGES; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= tag_new;
         for (int k = 1; k < FRONT_STAGES; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
         ox_ff <= RSZ_BITS'(req_item.col) + RSZ_BITS'(offx_ff);
         oy_ff <= RSZ_BITS'(req_item.row) + RSZ_BITS'(offy_ff);
         nx_ff <= NUM_BITS'(ox_ff) * NUM_BITS'(dm1x_ff);
         ny_ff <= NUM_BITS'(oy_ff) * NUM_BITS'(dm1y_ff);
      end
   end

   cip_div_lane u_div_x (
      .clock    (clock),
      .enable   (adv),
      .dividend (nx_ff),
      .divisor  (rw_ff),
      .quotient (qx)
   );

   cip_div_lane u_div_y (
      .clock    (clock),
      .enable   (adv),
      .dividend (ny_ff),
      .divisor  (rh_ff),
      .quotient (qy)
   );

   // ---------------------------------------------------------------
   // Memory sequencer: one write, or four neighbor reads per in-crop query
   // ---------------------------------------------------------------
   logic                 seq_v_ff;
   logic [1:0]           seq_cnt_ff;
   tag_type              seq_tag_ff;
   logic [INT_BITS-1:0]  x1_ff, y1_ff;
   logic [FRAC_BITS-1:0] fx_ff, fy_ff;
   logic [INT_BITS-1:0]  xi, yi;
   logic                 seq_read, seq_write, seq_done, credit_ok, tail_query;
   logic [FIFO_CNT_BITS-1:0] outst_ff;
   logic [ADDR_BITS-1:0] mem_addr;
   logic [COL_BITS-1:0]  rd_col;
   logic [ROW_BITS-1:0]  rd_row;
   logic [23:0]          mem [2**ADDR_BITS];
   logic [23:0]          rd_ff;

   assign xi         = qx[QUO_BITS-1:FRAC_BITS];
   assign yi         = qy[QUO_BITS-1:FRAC_BITS];
   assign tail_query = (tag_ff[FRONT_STAGES-1].action == ACT_QUERY);
   assign credit_ok  = (outst_ff < FIFO_CNT_BITS'(FIFO_DEPTH));
   assign seq_write  = seq_v_ff && (seq_tag_ff.action == ACT_WRITE);
   assign seq_read   = seq_v_ff && (seq_tag_ff.action == ACT_QUERY) && !seq_tag_ff.bad;
   assign seq_done   = seq_v_ff && (!seq_read || seq_cnt_ff == 2'd3);
   assign take       = v_ff[FRONT_STAGES-1] && (!seq_v_ff || seq_done)
                       && (!tail_query || credit_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_v_ff <= 1'b0;
      end else if (take) begin
         seq_v_ff <= 1'b1;
      end else if (seq_done) begin
         seq_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         seq_tag_ff <= tag_ff[FRONT_STAGES-1];
         seq_cnt_ff <= '0;
         x1_ff      <= (xi > limx_ff) ? limx_ff : xi;
         y1_ff      <= (yi > limy_ff) ? limy_ff : yi;
         fx_ff      <= qx[FRAC_BITS-1:0];
         fy_ff      <= qy[FRAC_BITS-1:0];
      end else if (seq_read) begin
         seq_cnt_ff <= seq_cnt_ff + 2'd1;
      end
   end

   // Neighbor order: top-left, top-right, bottom-left, bottom-right.
   assign rd_col = COL_BITS'(x1_ff + INT_BITS'(seq_cnt_ff[0]));
   assign rd_row = ROW_BITS'(y1_ff + INT_BITS'(seq_cnt_ff[1]));
   assign mem_addr = seq_write ? {seq_tag_ff.row[ROW_BITS-1:0], seq_tag_ff.col[COL_BITS-1:0]}
                               : {rd_row, rd_col};

   always_ff @(posedge clock) begin
      if (seq_write) begin
         mem[mem_addr] <= seq_tag_ff.pixel;
      end
      rd_ff <= mem[mem_addr];
   end

   // Queries past the address pipeline plus results queued never exceed the queue depth.
   logic rsp_acc;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_ff + FIFO_CNT_BITS'(take && tail_query) - FIFO_CNT_BITS'(rsp_acc);
      end
   end

   // ---------------------------------------------------------------
   // Sample capture and launch
   // ---------------------------------------------------------------
   logic                 cap_v_ff;
   logic [1:0]           cap_idx_ff, cap_ch_ff;
   logic [7:0]           s_ff [4];
   logic [7:0]           cap_byte;
   logic                 l1_v_ff, l1_bad_ff, l2_v_ff, l2_bad_ff;
   logic [1:0]           l1_ch_ff, l2_ch_ff;
   logic [FRAC_BITS-1:0] l1_fx_ff, l1_fy_ff, l2_fx_ff, l2_fy_ff;

   always_comb begin
      case (cap_ch_ff)
         CH_RED:   cap_byte = rd_ff[23:16];
         CH_GREEN: cap_byte = rd_ff[15:8];
         default:  cap_byte = rd_ff[7:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_v_ff <= 1'b0;
         l1_v_ff  <= 1'b0;
         l2_v_ff  <= 1'b0;
      end else begin
         cap_v_ff <= seq_read;
         l1_v_ff  <= seq_done && (seq_tag_ff.action == ACT_QUERY);
         l2_v_ff  <= l1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      cap_idx_ff <= seq_cnt_ff;
      cap_ch_ff  <= seq_tag_ff.channel;
      if (cap_v_ff) begin
         s_ff[cap_idx_ff] <= cap_byte;
      end
      l1_bad_ff <= seq_tag_ff.bad;
      l1_ch_ff  <= seq_tag_ff.channel;
      l1_fx_ff  <= fx_ff;
      l1_fy_ff  <= fy_ff;
      l2_bad_ff <= l1_bad_ff;
      l2_ch_ff  <= l1_ch_ff;
      l2_fx_ff  <= l1_fx_ff;
      l2_fy_ff  <= l1_fy_ff;
   end

   // ---------------------------------------------------------------
   // Blend and normalize
   // ---------------------------------------------------------------
   logic                 p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff;
   logic                 p1_bad_ff, p2_bad_ff, p3_bad_ff, p4_bad_ff;
   logic [1:0]           p1_ch_ff, p2_ch_ff, p3_ch_ff;
   logic [FRAC_BITS-1:0] p1_fy_ff;
   logic [FRAC_BITS:0]   gx, gy;
   logic [23:0]          a_ff, b_ff;
   logic [40:0]          ma_ff, mb_ff;
   logic [40:0]          msum;
   logic [7:0]           v_pix_ff;
   logic [21:0]          prod;
   logic signed [23:0]   t_ff, rnd, shr;
   logic signed [15:0]   sat;

   assign gx   = 17'h10000 - {1'b0, l2_fx_ff};
   assign gy   = 17'h10000 - {1'b0, p1_fy_ff};
   assign msum = ma_ff + mb_ff;
   assign prod = 22'(v_pix_ff) * 22'(norm_scale(p3_ch_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= l2_v_ff;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      // Horizontal blend of each row pair.
      a_ff      <= 24'(s_ff[0]) * 24'(gx) + 24'(s_ff[1]) * 24'(l2_fx_ff);
      b_ff      <= 24'(s_ff[2]) * 24'(gx) + 24'(s_ff[3]) * 24'(l2_fx_ff);
      p1_fy_ff  <= l2_fy_ff;
      p1_bad_ff <= l2_bad_ff;
      p1_ch_ff  <= l2_ch_ff;
      // Vertical weights.
      ma_ff     <= 41'(a_ff) * 41'(gy);
      mb_ff     <= 41'(b_ff) * 41'(p1_fy_ff);
      p2_bad_ff <= p1_bad_ff;
      p2_ch_ff  <= p1_ch_ff;
      // Drop the 32 fraction bits.
      v_pix_ff  <= msum[39:32];
      p3_bad_ff <= p2_bad_ff;
      p3_ch_ff  <= p2_ch_ff;
      // Scale and remove the channel mean, Q.20.
      t_ff      <= $signed({2'b00, prod}) - $signed({3'b000, norm_bias(p3_ch_ff)});
      p4_bad_ff <= p3_bad_ff;
   end

   // Round to Q3.12 and saturate.
   always_comb begin
      rnd = t_ff + 24'sd128;
      shr = rnd >>> 8;
      if (shr > 24'sd32767) begin
         sat = 16'sd32767;
      end else if (shr < -24'sd32768) begin
         sat = -16'sd32768;
      end else begin
         sat = shr[15:0];
      end
   end

   // ---------------------------------------------------------------
   // Result queue
   // ---------------------------------------------------------------
   rsp_item_type             fifo_ff [FIFO_DEPTH];
   rsp_item_type             push_item;
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_BITS-1:0] fcnt_ff;

   always_comb begin
      if (p4_bad_ff) begin
         push_item.value  = '0;
         push_item.status = STATUS_RANGE;
      end else begin
         push_item.value  = sat;
         push_item.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fcnt_ff   <= '0;
      end else begin
         if (p4_v_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_acc) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fcnt_ff <= fcnt_ff + FIFO_CNT_BITS'(p4_v_ff) - FIFO_CNT_BITS'(rsp_acc);
      end
   end

   always_ff @(posedge clock) begin
      if (p4_v_ff) begin
         fifo_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign rsp_valid = (fcnt_ff != '0);
   assign rsp_item  = fifo_ff[rd_ptr_ff];

endmodule

`default_nettype wire

@@ rtl/cip_checker.sv @@
`default_nettype none

module cip_checker import cip_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input rsp_item_type             rsp_item
);

   // A result waiting on the receiver stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // A result flagged out of range always carries a zero value.
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == STATUS_RANGE |-> rsp_item.value == 16'sd0)
      else $error("flagged result has nonzero value");

   // Reset empties the result queue.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // The size computation after reset keeps requests out.
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken before sizes were derived");

endmodule

bind clip_image_preprocessor cip_checker u_cip_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

`default_nettype wire
